// ----- src/cmf_pkg.sv -----
package cmf_pkg;

  localparam int OUT_W   = 23;
  localparam int OUT_DW  = ((2 * OUT_W + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_DW - 2 * OUT_W;
  localparam int CFG_W   = 32;
  localparam int CFG_AW  = 1;

  localparam logic [CFG_AW-1:0] CFG_COEF_I = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_COEF_Q = 1'd1;

  localparam logic [CFG_W-1:0] COEF_I_RESET = 32'd486037701;
  localparam logic [CFG_W-1:0] COEF_Q_RESET = 32'd3617957972;

  typedef struct packed {
    logic shift;
    logic adv;
  } cmf_ctl_t;

endpackage

// ----- src/cmf_tap_cell.sv -----
module cmf_tap_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmf_pkg::cmf_ctl_t             ctl,
  input  logic                          coef_i,
  input  logic                          coef_q,
  input  logic signed [SAMPLE_BITS-1:0] prev_i,
  input  logic signed [SAMPLE_BITS-1:0] prev_q,
  output logic signed [SAMPLE_BITS-1:0] tap_i,
  output logic signed [SAMPLE_BITS-1:0] tap_q,
  output logic signed [SAMPLE_BITS+1:0] term_x,
  output logic signed [SAMPLE_BITS+1:0] term_y
);

  localparam int TW = SAMPLE_BITS + 2;

  logic signed [SAMPLE_BITS-1:0] tap_i_r;
  logic signed [SAMPLE_BITS-1:0] tap_q_r;
  logic signed [TW-1:0]          term_x_r;
  logic signed [TW-1:0]          term_y_r;
  logic signed [TW-1:0]          ext_i;
  logic signed [TW-1:0]          ext_q;
  logic signed [TW-1:0]          i_by_ci;
  logic signed [TW-1:0]          q_by_cq;
  logic signed [TW-1:0]          q_by_ci;
  logic signed [TW-1:0]          i_by_cq;
  logic signed [TW-1:0]          term_x_nxt;
  logic signed [TW-1:0]          term_y_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_i_r <= '0;
      tap_q_r <= '0;
    end else if (ctl.shift) begin
      tap_i_r <= prev_i;
      tap_q_r <= prev_q;
    end
  end

  always_comb begin
    ext_i      = TW'(tap_i_r);
    ext_q      = TW'(tap_q_r);
    i_by_ci    = coef_i ? ext_i : -ext_i;
    q_by_cq    = coef_q ? ext_q : -ext_q;
    q_by_ci    = coef_i ? ext_q : -ext_q;
    i_by_cq    = coef_q ? ext_i : -ext_i;
    term_x_nxt = i_by_ci + q_by_cq;
    term_y_nxt = q_by_ci - i_by_cq;
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      term_x_r <= term_x_nxt;
      term_y_r <= term_y_nxt;
    end
  end

  assign tap_i  = tap_i_r;
  assign tap_q  = tap_q_r;
  assign term_x = term_x_r;
  assign term_y = term_y_r;

endmodule

// ----- src/cmf_adder_tree.sv -----
module cmf_adder_tree #(
  parameter int N_LEAF = 32,
  parameter int W_IN   = 18
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  cmf_pkg::cmf_ctl_t                      ctl,
  input  logic                                   in_valid,
  input  logic signed [W_IN-1:0]                 leaf [N_LEAF],
  output logic                                   out_valid,
  output logic signed [W_IN+$clog2(N_LEAF)-1:0]  sum
);

  localparam int LVLS = $clog2(N_LEAF);
  localparam int P    = 1 << LVLS;
  localparam int AW   = W_IN + LVLS;

  logic signed [AW-1:0] leaf_ext [P];
  logic signed [AW-1:0] node_r [1:P-1];
  logic [LVLS-1:0]      vld_r;
  logic [LVLS:0]        vld_nxt;

  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < N_LEAF) begin : g_used
      assign leaf_ext[j] = AW'(leaf[j]);
    end else begin : g_pad
      assign leaf_ext[j] = '0;
    end
  end

  for (genvar j = 1; j < P; j++) begin : g_node
    logic signed [AW-1:0] ca;
    logic signed [AW-1:0] cb;
    if (2 * j >= P) begin : g_from_leaf
      assign ca = leaf_ext[2 * j - P];
      assign cb = leaf_ext[2 * j + 1 - P];
    end else begin : g_from_node
      assign ca = node_r[2 * j];
      assign cb = node_r[2 * j + 1];
    end
    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        node_r[j] <= ca + cb;
      end
    end
  end

  assign vld_nxt = {vld_r, in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.adv) begin
      vld_r <= vld_nxt[LVLS-1:0];
    end
  end

  assign out_valid = vld_r[LVLS-1];
  assign sum       = node_r[1];

endmodule

// ----- src/complex_sign_matched_filter_top.sv -----
// Channel | Ports                  | Contents (low bit first)
// in      | in_tvalid/tready/tdata | sample_i, sample_q, zero fill to bytes
// out     | out_tvalid/tready/tdata| out_x (23), out_y (23), zero fill to 48
// cfg     | cfg_we/addr/wdata      | 0: coef_i_signs, 1: coef_q_signs
//
// One request is taken every cycle while the output is not stalled; once accepted,
// a request's result passes through the registered tap row, the registered term
// row and the levels of the adder tree.
// Reset clears the sample history and loads the default coefficient signs.
// A stall on the output freezes the whole pipeline and drops in_tready.
module complex_sign_matched_filter_top #(
  parameter int TAPS        = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // sample_i, sample_q
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // out_x, out_y
  output logic [cmf_pkg::OUT_DW-1:0]            out_tdata,
  input  logic                                  cfg_we,
  input  logic [cmf_pkg::CFG_AW-1:0]            cfg_addr,
  input  logic [cmf_pkg::CFG_W-1:0]             cfg_wdata
);

  import cmf_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int TW = SB + 2;
  localparam int AW = TW + $clog2(TAPS);

  logic [CFG_W-1:0]     coef_i_r;
  logic [CFG_W-1:0]     coef_q_r;
  cmf_ctl_t             ctl;
  logic                 adv;
  logic                 accept;
  logic                 v_tap_r;
  logic                 v_term_r;
  logic                 vld_x;
  logic                 vld_y;
  logic signed [SB-1:0] samp_i;
  logic signed [SB-1:0] samp_q;
  logic signed [SB-1:0] tap_i [TAPS];
  logic signed [SB-1:0] tap_q [TAPS];
  logic signed [TW-1:0] term_x [TAPS];
  logic signed [TW-1:0] term_y [TAPS];
  logic signed [AW-1:0] sum_x;
  logic signed [AW-1:0] sum_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_i_r <= COEF_I_RESET;
      coef_q_r <= COEF_Q_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_COEF_I: coef_i_r <= cfg_wdata;
        CFG_COEF_Q: coef_q_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv       = !out_tvalid || out_tready;
  assign accept    = in_tvalid && adv;
  assign in_tready = adv;
  assign ctl.adv   = adv;
  assign ctl.shift = accept;

  assign samp_i = in_tdata[SB-1:0];
  assign samp_q = in_tdata[2*SB-1:SB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_tap_r  <= 1'b0;
      v_term_r <= 1'b0;
    end else if (adv) begin
      v_tap_r  <= in_tvalid;
      v_term_r <= v_tap_r;
    end
  end

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    logic signed [SB-1:0] prev_i;
    logic signed [SB-1:0] prev_q;
    if (k == 0) begin : g_head
      assign prev_i = samp_i;
      assign prev_q = samp_q;
    end else begin : g_link
      assign prev_i = tap_i[k-1];
      assign prev_q = tap_q[k-1];
    end
    cmf_tap_cell #(
      .SAMPLE_BITS(SB)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .coef_i (coef_i_r[k]),
      .coef_q (coef_q_r[k]),
      .prev_i (prev_i),
      .prev_q (prev_q),
      .tap_i  (tap_i[k]),
      .tap_q  (tap_q[k]),
      .term_x (term_x[k]),
      .term_y (term_y[k])
    );
  end

  cmf_adder_tree #(
    .N_LEAF(TAPS),
    .W_IN  (TW)
  ) u_tree_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_valid  (v_term_r),
    .leaf      (term_x),
    .out_valid (vld_x),
    .sum       (sum_x)
  );

  cmf_adder_tree #(
    .N_LEAF(TAPS),
    .W_IN  (TW)
  ) u_tree_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_valid  (v_term_r),
    .leaf      (term_y),
    .out_valid (vld_y),
    .sum       (sum_y)
  );

  assign out_tvalid = vld_x;
  assign out_tdata  = {{OUT_PAD{1'b0}}, OUT_W'(sum_y), OUT_W'(sum_x)};

  a_tree_valid_agree: assert property (@(posedge clk) disable iff (!rst_n)
    vld_x == vld_y) else $error("adder tree valid bits disagree");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("result valid after reset");

  a_accept_fills_tap: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> v_tap_r) else $error("accepted request lost at tap row");

  a_term_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    v_term_r && !adv |=> v_term_r) else $error("term stage dropped on stall");

endmodule
